@@ hw/rtl/measurement_session_sequencer_macros.svh @@
// Assertion macros shared by the checking code.
`ifndef MEASUREMENT_SESSION_SEQUENCER_MACROS_SVH
`define MEASUREMENT_SESSION_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define MSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/mss_pkg.sv @@
`timescale 1ns / 1ps

package mss_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned MINUTE_W = 11;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned RETRY_W  = 4;
  localparam int unsigned SEC_W    = 14;
  localparam int unsigned IVL_W    = 24;
  localparam int unsigned TMO_W    = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Remaining ms at or above this saturate the seconds output.
  localparam int unsigned SEC_LIMIT_MS = 16384 * 1000;
  localparam int unsigned MS_W         = 24;
  localparam logic [SEC_W-1:0] SEC_MAX = '1;

  // x / 1000 == (x * DIV_RECIP) >> DIV_SHIFT for x < SEC_LIMIT_MS
  localparam int unsigned DIV_SHIFT  = 34;
  localparam int unsigned RECIP_W    = 25;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 25'd17179870;

  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES  = 3'd4;

  localparam logic [IVL_W-1:0]    RST_INTERVAL     = 24'd1800000;
  localparam logic [MINUTE_W-1:0] RST_WINDOW_START = 11'd360;
  localparam logic [MINUTE_W-1:0] RST_WINDOW_END   = 11'd1320;
  localparam logic [TMO_W-1:0]    RST_WAIT_TIMEOUT = 32'd300000;
  localparam logic [RETRY_W-1:0]  RST_MAX_RETRIES  = 4'd3;

  localparam logic [CODE_W-1:0] CODE_IDLE = 3'd0;
  localparam logic [CODE_W-1:0] CODE_WAIT = 3'd1;
  localparam logic [CODE_W-1:0] CODE_MEAS = 3'd2;
  localparam logic [CODE_W-1:0] CODE_STAB = 3'd3;
  localparam logic [CODE_W-1:0] CODE_XMIT = 3'd4;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 3'd0,
    OP_COMPLETE   = 3'd1,
    OP_FAILED     = 3'd2,
    OP_FORCE      = 3'd3,
    OP_RESCHEDULE = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WAIT = 4'b0010,
    ST_MEAS = 4'b0100,
    ST_XMIT = 4'b1000
  } state_t;

  typedef struct packed {
    logic            due;
    logic            sat;
    logic [MS_W-1:0] ms;
  } sec_req_t;

  function automatic logic [CODE_W-1:0] state_code(state_t st);
    logic [CODE_W-1:0] code;
    unique case (st)
      ST_IDLE: code = CODE_IDLE;
      ST_WAIT: code = CODE_WAIT;
      ST_MEAS: code = CODE_MEAS;
      ST_XMIT: code = CODE_XMIT;
      default: code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

@@ hw/rtl/mss_if.sv @@
`timescale 1ns / 1ps

interface mss_item_if;
  logic                         valid;
  logic                         ready;
  logic [mss_pkg::OP_W-1:0]     operation;
  logic [mss_pkg::NOW_W-1:0]    now_ms;
  logic                         time_valid;
  logic [mss_pkg::MINUTE_W-1:0] minute_of_day;
  logic                         finger_present;

  modport source (output valid, operation, now_ms, time_valid, minute_of_day,
                  finger_present, input ready);
  modport sink (input valid, operation, now_ms, time_valid, minute_of_day,
                finger_present, output ready);
endinterface

interface mss_result_if;
  logic                       valid;
  logic                       ready;
  logic [mss_pkg::CODE_W-1:0]  session_state;
  logic                       start_sensor;
  logic                       timeout_notice;
  logic                       skipped_outside_window;
  logic [mss_pkg::RETRY_W-1:0] retry_count;
  logic [mss_pkg::SEC_W-1:0]   seconds_until_next;

  modport source (output valid, session_state, start_sensor, timeout_notice,
                  skipped_outside_window, retry_count, seconds_until_next,
                  input ready);
  modport sink (input valid, session_state, start_sensor, timeout_notice,
                skipped_outside_window, retry_count, seconds_until_next,
                output ready);
endinterface

interface mss_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mss_pkg::CFG_IDX_W-1:0]  index;
  logic [mss_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/mss_sec_div.sv @@
`timescale 1ns / 1ps

module mss_sec_div (
  input  logic                      clk,
  input  logic                      load,
  input  mss_pkg::sec_req_t         req,
  output logic [mss_pkg::SEC_W-1:0] secs
);

  localparam int unsigned PROD_W = mss_pkg::MS_W + mss_pkg::RECIP_W;

  logic [PROD_W-1:0]         prod;
  logic [mss_pkg::SEC_W-1:0] quot;

  assign prod = PROD_W'(req.ms) * PROD_W'(mss_pkg::DIV_RECIP);
  assign quot = prod[mss_pkg::DIV_SHIFT +: mss_pkg::SEC_W];

  always_ff @(posedge clk) begin
    if (load) begin
      priority if (req.due) begin
        secs <= '0;
      end else if (req.sat) begin
        secs <= mss_pkg::SEC_MAX;
      end else begin
        secs <= quot;
      end
    end
  end

endmodule

@@ hw/rtl/measurement_session_sequencer.sv @@
`timescale 1ns / 1ps
// Request path: an accepted request is captured in the input register, then passes
// the state update register and the divide-by-1000 register, which drives the result.
// Throughput: one request per cycle; each stage holds only while the next is full.
// Reset (rst, synchronous): idle state, times and retry count zero, pipeline
// empty, configuration registers back to their default values.

module measurement_session_sequencer #(
  parameter int unsigned TIME_BITS = mss_pkg::TIME_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  mss_item_if.sink     item,
  mss_result_if.source result,
  mss_cfg_if.sink      cfg
);

  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned CW = (TW > mss_pkg::TMO_W) ? TW : mss_pkg::TMO_W;
  localparam int unsigned SW = (TW > mss_pkg::MS_W + 1) ? TW : mss_pkg::MS_W + 1;

  // configuration
  logic [mss_pkg::IVL_W-1:0]    interval;
  logic [mss_pkg::MINUTE_W-1:0] win_start;
  logic [mss_pkg::MINUTE_W-1:0] win_end;
  logic [mss_pkg::TMO_W-1:0]    wait_tmo;
  logic [mss_pkg::RETRY_W-1:0]  max_retries;

  // input stage
  logic                         v0;
  mss_pkg::op_t                 op0;
  logic [TW-1:0]                now0;
  logic                         tvalid0;
  logic [mss_pkg::MINUTE_W-1:0] minute0;
  logic                         finger0;

  // session state
  mss_pkg::state_t             st, st_next;
  logic [TW-1:0]               entry;
  logic [TW-1:0]               due, due_next;
  logic [mss_pkg::RETRY_W-1:0] retry, retry_next;

  // result stage one
  logic                        v1;
  logic [mss_pkg::CODE_W-1:0]  code1;
  logic                        start1, tmo1, skip1;
  logic [mss_pkg::RETRY_W-1:0] retry1;
  mss_pkg::sec_req_t           req1;

  // result stage two
  logic                        v2;
  logic [mss_pkg::CODE_W-1:0]  code2;
  logic                        start2, tmo2, skip2;
  logic [mss_pkg::RETRY_W-1:0] retry2;
  logic [mss_pkg::SEC_W-1:0]   secs2;

  logic r0, r1, r2;
  logic [CW-1:0] now_ext, ivl_ext;
  logic [TW-1:0] ivl_t, sched_val, back_cur, elapsed, rem, back;
  logic [SW-1:0] rem_ext;
  logic due_cur, timed_out, in_win, sched;
  logic start_c, tmo_c, skip_c;

  assign r2 = !v2 || result.ready;
  assign r1 = !v1 || r2;
  assign r0 = !v0 || r1;
  assign item.ready = r0;
  assign cfg.ready  = 1'b1;

  assign now_ext = CW'(item.now_ms);
  assign ivl_ext = CW'(interval);
  assign ivl_t   = ivl_ext[TW-1:0];

  assign sched_val = now0 + ivl_t;
  assign back_cur  = now0 - due;
  assign due_cur   = !back_cur[TW-1];
  assign elapsed   = now0 - entry;
  assign timed_out = CW'(elapsed) > CW'(wait_tmo);

  always_comb begin
    if (!tvalid0 || win_start == win_end) begin
      in_win = 1'b1;
    end else if (win_start < win_end) begin
      in_win = (minute0 >= win_start) && (minute0 < win_end);
    end else begin
      in_win = (minute0 >= win_start) || (minute0 < win_end);
    end
  end

  always_comb begin
    st_next    = st;
    retry_next = retry;
    sched      = 1'b0;
    start_c    = 1'b0;
    tmo_c      = 1'b0;
    skip_c     = 1'b0;
    unique case (op0)
      mss_pkg::OP_TICK: begin
        if (st == mss_pkg::ST_IDLE) begin
          if (due_cur) begin
            if (!in_win) begin
              sched  = 1'b1;
              skip_c = 1'b1;
            end else begin
              retry_next = '0;
              st_next    = mss_pkg::ST_WAIT;
            end
          end
        end else if (st == mss_pkg::ST_WAIT) begin
          if (timed_out) begin
            tmo_c   = 1'b1;
            sched   = 1'b1;
            st_next = mss_pkg::ST_IDLE;
          end else if (finger0) begin
            start_c = 1'b1;
            st_next = mss_pkg::ST_MEAS;
          end
        end
      end
      mss_pkg::OP_COMPLETE: begin
        retry_next = '0;
        st_next    = mss_pkg::ST_XMIT;
      end
      mss_pkg::OP_FAILED: begin
        if (retry < max_retries) begin
          retry_next = retry + mss_pkg::RETRY_W'(1);
          st_next    = mss_pkg::ST_WAIT;
        end else begin
          retry_next = '0;
          sched      = 1'b1;
          st_next    = mss_pkg::ST_IDLE;
        end
      end
      mss_pkg::OP_FORCE: begin
        st_next = mss_pkg::ST_WAIT;
      end
      mss_pkg::OP_RESCHEDULE: begin
        sched = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // after a reschedule the due time sits exactly one interval ahead
  assign due_next = sched ? sched_val : due;
  assign rem      = sched ? ivl_t : due - now0;
  assign back     = sched ? -ivl_t : back_cur;
  assign rem_ext  = SW'(rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      interval    <= mss_pkg::RST_INTERVAL;
      win_start   <= mss_pkg::RST_WINDOW_START;
      win_end     <= mss_pkg::RST_WINDOW_END;
      wait_tmo    <= mss_pkg::RST_WAIT_TIMEOUT;
      max_retries <= mss_pkg::RST_MAX_RETRIES;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        mss_pkg::CFG_INTERVAL:     interval    <= cfg.data[mss_pkg::IVL_W-1:0];
        mss_pkg::CFG_WINDOW_START: win_start   <= cfg.data[mss_pkg::MINUTE_W-1:0];
        mss_pkg::CFG_WINDOW_END:   win_end     <= cfg.data[mss_pkg::MINUTE_W-1:0];
        mss_pkg::CFG_WAIT_TIMEOUT: wait_tmo    <= cfg.data[mss_pkg::TMO_W-1:0];
        mss_pkg::CFG_MAX_RETRIES:  max_retries <= cfg.data[mss_pkg::RETRY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (r0) begin
      v0 <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r0 && item.valid) begin
      op0     <= mss_pkg::op_t'(item.operation);
      now0    <= now_ext[TW-1:0];
      tvalid0 <= item.time_valid;
      minute0 <= item.minute_of_day;
      finger0 <= item.finger_present;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= mss_pkg::ST_IDLE;
      entry <= '0;
      due   <= '0;
      retry <= '0;
      v1    <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= v0;
      end
      if (r1 && v0) begin
        st    <= st_next;
        due   <= due_next;
        retry <= retry_next;
        if (st_next != st) begin
          entry <= now0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && v0) begin
      code1    <= mss_pkg::state_code(st_next);
      start1   <= start_c;
      tmo1     <= tmo_c;
      skip1    <= skip_c;
      retry1   <= retry_next;
      req1.due <= !back[TW-1];
      req1.sat <= rem_ext >= SW'(mss_pkg::SEC_LIMIT_MS);
      req1.ms  <= rem_ext[mss_pkg::MS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      code2  <= code1;
      start2 <= start1;
      tmo2   <= tmo1;
      skip2  <= skip1;
      retry2 <= retry1;
    end
  end

  mss_sec_div u_sec_div (
    .clk  (clk),
    .load (r2 && v1),
    .req  (req1),
    .secs (secs2)
  );

  assign result.valid                  = v2;
  assign result.session_state          = code2;
  assign result.start_sensor           = start2;
  assign result.timeout_notice         = tmo2;
  assign result.skipped_outside_window = skip2;
  assign result.retry_count            = retry2;
  assign result.seconds_until_next     = secs2;

endmodule

@@ hw/rtl/mss_port_check.sv @@
`timescale 1ns / 1ps
`include "measurement_session_sequencer_macros.svh"

module mss_port_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        valid,
  input logic                        ready,
  input logic [mss_pkg::CODE_W-1:0]  session_state,
  input logic                        start_sensor,
  input logic                        timeout_notice,
  input logic                        skipped_outside_window,
  input logic [mss_pkg::RETRY_W-1:0] retry_count,
  input logic [mss_pkg::SEC_W-1:0]   seconds_until_next
);

  `MSS_ASSERT_IMPL(a_pulse_excl, valid, ($onehot0({start_sensor, timeout_notice, skipped_outside_window})), "more than one pulse in a result")
  `MSS_ASSERT_IMPL(a_start_meas, (valid && start_sensor), (session_state == mss_pkg::CODE_MEAS), "sensor start outside measuring")
  `MSS_ASSERT_IMPL(a_drop_idle, (valid && (timeout_notice || skipped_outside_window)), (session_state == mss_pkg::CODE_IDLE), "timeout or skip not in idle")
  `MSS_ASSERT_NEXT(a_hold, (valid && !ready), (valid && $stable(session_state) && $stable(retry_count) && $stable(seconds_until_next) && $stable(start_sensor)), "stalled result changed")

endmodule

bind measurement_session_sequencer mss_port_check u_port_check (
  .clk                    (clk),
  .rst                    (rst),
  .valid                  (result.valid),
  .ready                  (result.ready),
  .session_state          (result.session_state),
  .start_sensor           (result.start_sensor),
  .timeout_notice         (result.timeout_notice),
  .skipped_outside_window (result.skipped_outside_window),
  .retry_count            (result.retry_count),
  .seconds_until_next     (result.seconds_until_next)
);
